// File: sv/mcsl_pkg.sv
// ============================================================================
// mcsl_pkg
// Shared types, widths and register codes for the monotonized-central slope
// limiter stencil.
// ============================================================================
`default_nettype none

package mcsl_pkg;

   // Default depth of one line-store row.
   localparam int MAX_ROW_CELLS_DEF = 1024;

   // Field widths.
   localparam int SAMPLE_W   = 16;
   localparam int SLOPE_W    = 32;
   localparam int ROW_W      = 16;
   localparam int COL_W      = 10;
   localparam int LEN_W      = 11;
   localparam int INV_W      = 16;
   localparam int CSR_W      = 16;
   localparam int NUM_FIELDS = 3;

   // Field order inside a packed line-store word.
   localparam int FLD_DEPTH = 0;
   localparam int FLD_XVEL  = 1;
   localparam int FLD_YVEL  = 2;

   // Register reset values.
   localparam logic [LEN_W-1:0] ROW_LENGTH_RST = LEN_W'(1024);
   localparam logic [ROW_W-1:0] ROW_COUNT_RST  = ROW_W'(3);
   localparam logic [INV_W-1:0] INV_DX_RST     = INV_W'(256);
   localparam logic [INV_W-1:0] INV_DY_RST     = INV_W'(256);

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_ROW_LENGTH = 2'd0,
      CSR_ROW_COUNT  = 2'd1,
      CSR_INV_DX     = 2'd2,
      CSR_INV_DY     = 2'd3
   } csr_index_type;

   // Stage load strobes shared by all lanes.
   typedef struct packed {
      logic ld2;
      logic ld3;
      logic ld4;
   } ctl_type;

   // Cell position and column qualifier that travel beside the lanes.
   typedef struct packed {
      logic             col_valid;
      logic [ROW_W-1:0] cell_row;
      logic [COL_W-1:0] cell_col;
   } meta_type;

endpackage

`default_nettype wire

// File: sv/mcsl_ram.sv
// ============================================================================
// mcsl_ram
// Generic single-write, dual-read RAM with registered, read-first outputs.
// ============================================================================
`default_nettype none

module mcsl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Reads return the contents from before a write in the same cycle.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// File: sv/mcsl_lane.sv
// ============================================================================
// mcsl_lane
// One limiter lane: differences, monotonized-central minimum, scaling by the
// reciprocal spacing and sign restore, over three register stages.
// ============================================================================
`default_nettype none

module mcsl_lane (
   input  logic                                  clock,
   input  mcsl_pkg::ctl_type                     ctl,
   input  logic signed [mcsl_pkg::SAMPLE_W-1:0]  prev_sample,
   input  logic signed [mcsl_pkg::SAMPLE_W-1:0]  cur_sample,
   input  logic signed [mcsl_pkg::SAMPLE_W-1:0]  next_sample,
   input  logic        [mcsl_pkg::INV_W-1:0]     inv,
   output logic signed [mcsl_pkg::SLOPE_W-1:0]   slope
);
   import mcsl_pkg::*;

   localparam int DIFF_W = SAMPLE_W + 1;
   localparam int MAG_W  = SAMPLE_W;
   localparam int QUAD_W = SAMPLE_W + 2;
   localparam int PROD_W = MAG_W + INV_W;

   logic signed [DIFF_W-1:0] f_ff, b_ff, d_ff;
   logic signed [DIFF_W-1:0] f_in, b_in, d_in;
   logic signed [DIFF_W-1:0] f_abs, b_abs, d_abs;
   logic [QUAD_W-1:0]        f_quad, b_quad, d_wide, min_fb, min_all;
   logic [MAG_W-1:0]         m_ff, m_in;
   logic                     keep3_ff, keep3_in, neg3_ff, neg3_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic                     keep4_ff, neg4_ff;
   logic signed [SLOPE_W-1:0] mag;

   // Stage 2: forward, backward and central differences.
   always_comb begin
      f_in = DIFF_W'(next_sample) - DIFF_W'(cur_sample);
      b_in = DIFF_W'(cur_sample) - DIFF_W'(prev_sample);
      d_in = DIFF_W'(next_sample) - DIFF_W'(prev_sample);
   end

   always_ff @(posedge clock) begin
      if (ctl.ld2) begin
         f_ff <= f_in;
         b_ff <= b_in;
         d_ff <= d_in;
      end
   end

   // Stage 3: sign agreement and min(4|f|, 4|b|, |d|); the result never
   // exceeds |d|, so it fits the sample width.
   always_comb begin
      f_abs    = f_ff[DIFF_W-1] ? -f_ff : f_ff;
      b_abs    = b_ff[DIFF_W-1] ? -b_ff : b_ff;
      d_abs    = d_ff[DIFF_W-1] ? -d_ff : d_ff;
      f_quad   = {f_abs[MAG_W-1:0], 2'b00};
      b_quad   = {b_abs[MAG_W-1:0], 2'b00};
      d_wide   = {2'b00, d_abs[MAG_W-1:0]};
      min_fb   = (f_quad < b_quad) ? f_quad : b_quad;
      min_all  = (min_fb < d_wide) ? min_fb : d_wide;
      m_in     = min_all[MAG_W-1:0];
      keep3_in = ((f_ff > 0) && (b_ff > 0)) || ((f_ff < 0) && (b_ff < 0));
      neg3_in  = f_ff[DIFF_W-1];
   end

   always_ff @(posedge clock) begin
      if (ctl.ld3) begin
         m_ff     <= m_in;
         keep3_ff <= keep3_in;
         neg3_ff  <= neg3_in;
      end
   end

   // Stage 4: scale by the reciprocal spacing.
   assign prod_in = m_ff * inv;

   always_ff @(posedge clock) begin
      if (ctl.ld4) begin
         prod_ff  <= prod_in;
         keep4_ff <= keep3_ff;
         neg4_ff  <= neg3_ff;
      end
   end

   // Halve to 16 fraction bits and restore the sign. The magnitude stays
   // below 2^31, so the signed range is never exceeded.
   assign mag = SLOPE_W'(prod_ff >> 1);

   always_comb begin
      if (!keep4_ff) begin
         slope = '0;
      end else if (neg4_ff) begin
         slope = -mag;
      end else begin
         slope = mag;
      end
   end

endmodule

`default_nettype wire

// File: sv/mcsl_merge.sv
// ============================================================================
// mcsl_merge
// Output register: gathers the six lane slopes and the cell position into one
// result transaction and blanks the column slopes of ghost columns.
// ============================================================================
`default_nettype none

module mcsl_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 ld,
   input  logic signed [mcsl_pkg::SLOPE_W-1:0]  row_slope [mcsl_pkg::NUM_FIELDS],
   input  logic signed [mcsl_pkg::SLOPE_W-1:0]  col_slope [mcsl_pkg::NUM_FIELDS],
   input  mcsl_pkg::meta_type                   meta,
   output logic                                 out_ready,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [mcsl_pkg::SLOPE_W-1:0]  rsp_depth_slope_row,
   output logic signed [mcsl_pkg::SLOPE_W-1:0]  rsp_depth_slope_col,
   output logic signed [mcsl_pkg::SLOPE_W-1:0]  rsp_xvel_slope_row,
   output logic signed [mcsl_pkg::SLOPE_W-1:0]  rsp_xvel_slope_col,
   output logic signed [mcsl_pkg::SLOPE_W-1:0]  rsp_yvel_slope_row,
   output logic signed [mcsl_pkg::SLOPE_W-1:0]  rsp_yvel_slope_col,
   output logic                                 rsp_col_valid,
   output logic        [mcsl_pkg::ROW_W-1:0]    rsp_cell_row,
   output logic        [mcsl_pkg::COL_W-1:0]    rsp_cell_col
);
   import mcsl_pkg::*;

   logic                      valid_ff, valid_in;
   logic signed [SLOPE_W-1:0] row_ff [NUM_FIELDS];
   logic signed [SLOPE_W-1:0] col_ff [NUM_FIELDS];
   logic signed [SLOPE_W-1:0] col_in [NUM_FIELDS];
   meta_type                  meta_ff;

   // The register can take a new transaction when empty or being drained.
   assign out_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (out_ready) begin
         valid_in = ld;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Column slopes of ghost columns are forced to zero.
   always_comb begin
      for (int k = 0; k < NUM_FIELDS; k++) begin
         col_in[k] = meta.col_valid ? col_slope[k] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ld && out_ready) begin
         row_ff  <= row_slope;
         col_ff  <= col_in;
         meta_ff <= meta;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_depth_slope_row = row_ff[FLD_DEPTH];
   assign rsp_depth_slope_col = col_ff[FLD_DEPTH];
   assign rsp_xvel_slope_row  = row_ff[FLD_XVEL];
   assign rsp_xvel_slope_col  = col_ff[FLD_XVEL];
   assign rsp_yvel_slope_row  = row_ff[FLD_YVEL];
   assign rsp_yvel_slope_col  = col_ff[FLD_YVEL];
   assign rsp_col_valid       = meta_ff.col_valid;
   assign rsp_cell_row        = meta_ff.cell_row;
   assign rsp_cell_col        = meta_ff.cell_col;

endmodule

`default_nettype wire

// File: sv/mc_slope_limiter_stencil.sv
// ============================================================================
// mc_slope_limiter_stencil
// Raster-order slope limiter: two row banks, shared by the three fields, feed
// six limiter lanes (three fields, row and column direction) whose results
// merge into one output transaction per interior-row cell.
// ============================================================================
//
//   Channel  Direction  Handshake           Carries
//   req_     in         req_valid/ready     one grid cell: depth, x and y vel
//   rsp_     out        rsp_valid/ready     six limited slopes, cell position
//   csr_     in         csr_we (no wait)    row_length, row_count, inv_dx/dy
//
// One cell per clock is sustained while the output is ready; each cell passes
// line-store read, differences, minimum, multiply and output registers.
// Cells of the first two rows of a grid are consumed without a result.
// Reset clears the control path, counters and configuration registers; the
// line stores need no clearing, because each row is written before it is read.
// A stalled output backs up through the pipeline one stage at a time, so
// empty stages keep taking cells until the pipeline is full.
// ============================================================================
`default_nettype none

module mc_slope_limiter_stencil #(
   parameter int MAX_ROW_CELLS = mcsl_pkg::MAX_ROW_CELLS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [mcsl_pkg::SAMPLE_W-1:0] req_depth_sample,
   input  logic signed [mcsl_pkg::SAMPLE_W-1:0] req_xvel_sample,
   input  logic signed [mcsl_pkg::SAMPLE_W-1:0] req_yvel_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [mcsl_pkg::SLOPE_W-1:0]  rsp_depth_slope_row,
   output logic signed [mcsl_pkg::SLOPE_W-1:0]  rsp_depth_slope_col,
   output logic signed [mcsl_pkg::SLOPE_W-1:0]  rsp_xvel_slope_row,
   output logic signed [mcsl_pkg::SLOPE_W-1:0]  rsp_xvel_slope_col,
   output logic signed [mcsl_pkg::SLOPE_W-1:0]  rsp_yvel_slope_row,
   output logic signed [mcsl_pkg::SLOPE_W-1:0]  rsp_yvel_slope_col,
   output logic                                 rsp_col_valid,
   output logic        [mcsl_pkg::ROW_W-1:0]    rsp_cell_row,
   output logic        [mcsl_pkg::COL_W-1:0]    rsp_cell_col,
   input  logic                                 csr_we,
   input  mcsl_pkg::csr_index_type              csr_index,
   input  logic        [mcsl_pkg::CSR_W-1:0]    csr_wdata
);
   import mcsl_pkg::*;

   localparam int CW      = $clog2(MAX_ROW_CELLS);
   localparam int CMPW    = (CW > LEN_W) ? CW : LEN_W;
   localparam int LEN_CAP = (MAX_ROW_CELLS < (1 << LEN_W) - 1) ?
                            MAX_ROW_CELLS : (1 << LEN_W) - 1;
   localparam int DATA_W  = NUM_FIELDS * SAMPLE_W;

   // Configuration registers.
   logic [LEN_W-1:0] row_length_ff, row_length_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic [INV_W-1:0] inv_dx_ff, inv_dx_in;
   logic [INV_W-1:0] inv_dy_ff, inv_dy_in;
   logic             cfg_hit;

   // Raster position.
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [LEN_W-1:0] len_eff;
   logic [ROW_W-1:0] rows_eff;
   logic [CMPW-1:0]  col_ext, len_ext;
   logic             last_col, last_row, cv;

   // Handshake and pipeline control.
   logic    accept;
   logic    v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic    rdy1, rdy2, rdy3, rdy4, out_ready, ld_out;
   ctl_type ctl;

   // Line stores and stage 1.
   logic [DATA_W-1:0] wr_word;
   logic [DATA_W-1:0] rd_a [2];
   logic [DATA_W-1:0] rd_b [2];
   logic              s1_par_ff;
   logic [DATA_W-1:0] s1_next_ff, mid_left_ff;
   logic [DATA_W-1:0] s1_prev, s1_mid, s1_right;
   meta_type          meta_in, s1_meta_ff, s2_meta_ff, s3_meta_ff, s4_meta_ff;

   logic signed [SLOPE_W-1:0] row_slope [NUM_FIELDS];
   logic signed [SLOPE_W-1:0] col_slope [NUM_FIELDS];

   // Register writes; a write to any register restarts the raster.
   always_comb begin
      row_length_in = row_length_ff;
      row_count_in  = row_count_ff;
      inv_dx_in     = inv_dx_ff;
      inv_dy_in     = inv_dy_ff;
      cfg_hit       = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_ROW_LENGTH: begin
               row_length_in = csr_wdata[LEN_W-1:0];
               cfg_hit       = 1'b1;
            end
            CSR_ROW_COUNT: begin
               row_count_in = csr_wdata[ROW_W-1:0];
               cfg_hit      = 1'b1;
            end
            CSR_INV_DX: begin
               inv_dx_in = csr_wdata[INV_W-1:0];
               cfg_hit   = 1'b1;
            end
            CSR_INV_DY: begin
               inv_dy_in = csr_wdata[INV_W-1:0];
               cfg_hit   = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LENGTH_RST;
         row_count_ff  <= ROW_COUNT_RST;
         inv_dx_ff     <= INV_DX_RST;
         inv_dy_ff     <= INV_DY_RST;
      end else begin
         row_length_ff <= row_length_in;
         row_count_ff  <= row_count_in;
         inv_dx_ff     <= inv_dx_in;
         inv_dy_ff     <= inv_dy_in;
      end
   end

   // Effective grid size: row length clamped to the store depth, at least
   // three cells and three rows.
   always_comb begin
      if (row_length_ff < LEN_W'(3)) begin
         len_eff = LEN_W'(3);
      end else if (row_length_ff > LEN_W'(LEN_CAP)) begin
         len_eff = LEN_W'(LEN_CAP);
      end else begin
         len_eff = row_length_ff;
      end
      rows_eff = (row_count_ff < ROW_W'(3)) ? ROW_W'(3) : row_count_ff;
      col_ext  = CMPW'(col_ff);
      len_ext  = CMPW'(len_eff);
      last_col = (col_ext == len_ext - CMPW'(1));
      last_row = (row_ff == rows_eff - ROW_W'(1));
      cv       = (col_ff != '0) && !last_col;
   end

   // Raster counters.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Ready chain: each stage moves when the one after it is empty or moving.
   always_comb begin
      rdy4      = !v4_ff || out_ready;
      rdy3      = !v3_ff || rdy4;
      rdy2      = !v2_ff || rdy3;
      rdy1      = !v1_ff || rdy2;
      req_ready = rdy1;
      accept    = req_valid && rdy1;
      ctl.ld2   = v1_ff && rdy2;
      ctl.ld3   = v2_ff && rdy3;
      ctl.ld4   = v3_ff && rdy4;
      ld_out    = v4_ff;
      v1_in     = rdy1 ? (accept && (row_ff >= ROW_W'(2))) : v1_ff;
      v2_in     = rdy2 ? v1_ff : v2_ff;
      v3_in     = rdy3 ? v2_ff : v3_ff;
      v4_in     = rdy4 ? v3_ff : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // Line stores, one bank per row parity. Port A reads column c of both
   // banks, port B column c+1; the current bank is rewritten at column c.
   assign wr_word = {req_yvel_sample, req_xvel_sample, req_depth_sample};

   for (genvar g = 0; g < 2; g++) begin : g_bank
      mcsl_ram #(
         .WIDTH (DATA_W),
         .DEPTH (MAX_ROW_CELLS)
      ) u_ram (
         .clock     (clock),
         .wr_en     (accept && (row_ff[0] == 1'(g))),
         .wr_addr   (col_ff),
         .wr_data   (wr_word),
         .rd_en     (accept),
         .rd_addr_a (col_ff),
         .rd_addr_b (col_ff + CW'(1)),
         .rd_data_a (rd_a[g]),
         .rd_data_b (rd_b[g])
      );
   end

   // Stage 1: incoming samples and cell position beside the store reads.
   always_comb begin
      meta_in.col_valid = cv;
      meta_in.cell_row  = row_ff - ROW_W'(1);
      meta_in.cell_col  = COL_W'(col_ff);
      s1_prev           = rd_a[s1_par_ff];
      s1_mid            = rd_a[~s1_par_ff];
      s1_right          = rd_b[~s1_par_ff];
   end

   // The left neighbour is the previous transaction's centre sample.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_par_ff   <= row_ff[0];
         s1_next_ff  <= wr_word;
         s1_meta_ff  <= meta_in;
         mid_left_ff <= s1_mid;
      end
   end

   // Position travels beside the lanes.
   always_ff @(posedge clock) begin
      if (ctl.ld2) begin
         s2_meta_ff <= s1_meta_ff;
      end
      if (ctl.ld3) begin
         s3_meta_ff <= s2_meta_ff;
      end
      if (ctl.ld4) begin
         s4_meta_ff <= s3_meta_ff;
      end
   end

   // Limiter lanes: row direction and column direction for each field.
   for (genvar k = 0; k < NUM_FIELDS; k++) begin : g_field
      mcsl_lane u_row_lane (
         .clock       (clock),
         .ctl         (ctl),
         .prev_sample (s1_prev[k*SAMPLE_W +: SAMPLE_W]),
         .cur_sample  (s1_mid[k*SAMPLE_W +: SAMPLE_W]),
         .next_sample (s1_next_ff[k*SAMPLE_W +: SAMPLE_W]),
         .inv         (inv_dx_ff),
         .slope       (row_slope[k])
      );

      mcsl_lane u_col_lane (
         .clock       (clock),
         .ctl         (ctl),
         .prev_sample (mid_left_ff[k*SAMPLE_W +: SAMPLE_W]),
         .cur_sample  (s1_mid[k*SAMPLE_W +: SAMPLE_W]),
         .next_sample (s1_right[k*SAMPLE_W +: SAMPLE_W]),
         .inv         (inv_dy_ff),
         .slope       (col_slope[k])
      );
   end

   // Merge into the output register.
   mcsl_merge u_merge (
      .clock               (clock),
      .reset               (reset),
      .ld                  (ld_out),
      .row_slope           (row_slope),
      .col_slope           (col_slope),
      .meta                (s4_meta_ff),
      .out_ready           (out_ready),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_depth_slope_row (rsp_depth_slope_row),
      .rsp_depth_slope_col (rsp_depth_slope_col),
      .rsp_xvel_slope_row  (rsp_xvel_slope_row),
      .rsp_xvel_slope_col  (rsp_xvel_slope_col),
      .rsp_yvel_slope_row  (rsp_yvel_slope_row),
      .rsp_yvel_slope_col  (rsp_yvel_slope_col),
      .rsp_col_valid       (rsp_col_valid),
      .rsp_cell_row        (rsp_cell_row),
      .rsp_cell_col        (rsp_cell_col)
   );

   // The column counter never leaves the effective row.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ext < len_ext)
      else $error("column counter beyond row length");

   // The row counter never leaves the effective grid.
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff < rows_eff)
      else $error("row counter beyond row count");

   // Ghost columns carry zero column slopes.
   a_ghost_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_col_valid |->
         (rsp_depth_slope_col == '0) && (rsp_xvel_slope_col == '0) &&
         (rsp_yvel_slope_col == '0))
      else $error("ghost column with nonzero column slope");

   // The left ghost column is never marked as interior.
   a_left_ghost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_col_valid |-> rsp_cell_col != '0)
      else $error("column zero marked interior");

endmodule

`default_nettype wire
